>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands shared by the RTL; compiled out when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed");

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hdl/lzsd_pkg.sv
// ----------------------------------------------------------------------------
// lzsd_pkg
// Shared types and constants of the LZSS stream decompressor.
// ----------------------------------------------------------------------------
`default_nettype none

package lzsd_pkg;

    localparam int WINDOW_DEPTH = 4096;
    localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
    localparam int HDR_BYTES    = 4;
    localparam int HDR_W        = 3;
    localparam int GROUP_TOKENS = 8;
    localparam int FLAGS_W      = 4;
    localparam int MIN_MATCH    = 3;
    localparam int LEN_W        = 5;
    localparam int SIZE_W       = 32;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_COPY_RD,
        S_COPY_WR
    } t_state;

    typedef enum logic [1:0] {
        PH_CTRL,
        PH_TOKEN,
        PH_MATCH2
    } t_phase;

    // controller -> datapath
    typedef struct packed {
        logic clear_wr;
        logic accept;
        logic copy_rd;
        logic copy_wr;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic wp_last;
        logic in_emits;
        logic in_starts_copy;
        logic out_free;
        logic copy_end;
    } t_stat;

endpackage

`default_nettype wire

>>> hdl/lzsd_datapath.sv
// ----------------------------------------------------------------------------
// lzsd_datapath
// Stream parser registers, history window memory and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lzsd_datapath
    import lzsd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_stat            o_stat,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_out_ready,
    output logic             o_out_valid,
    output logic [7:0]       o_out_byte,
    output logic             o_run_last,
    output logic             o_stream_done
);

    logic [7:0]         r_history [WINDOW_DEPTH];
    logic [7:0]         r_rd_data;

    logic [WIN_AW-1:0]  r_wp,          n_wp;
    logic [SIZE_W-1:0]  r_rem,         n_rem;
    logic [HDR_W-1:0]   r_hdr_idx,     n_hdr_idx;
    logic [7:0]         r_flag_bits,   n_flag_bits;
    logic [FLAGS_W-1:0] r_flags_left,  n_flags_left;
    t_phase             r_phase,       n_phase;
    logic [7:0]         r_pending_low, n_pending_low;
    logic [LEN_W-1:0]   r_len,         n_len;
    logic [WIN_AW-1:0]  r_dist,        n_dist;

    logic               r_out_valid;
    logic [7:0]         r_out_byte;
    logic               r_run_last;
    logic               r_stream_done;

    logic               w_body;
    logic               w_lit;
    logic               w_out_load;
    logic               w_we;
    logic [7:0]         w_wdata;
    logic [WIN_AW-1:0]  w_raddr;
    logic               w_last_byte;
    logic [SIZE_W-1:0]  w_hdr_val;

    assign w_body      = (r_hdr_idx == HDR_W'(HDR_BYTES));
    assign w_lit       = w_body && (r_phase == PH_TOKEN) && !r_flag_bits[0];
    assign w_out_load  = (i_cmd.accept && w_lit) || i_cmd.copy_wr;
    assign w_last_byte = (r_rem == SIZE_W'(1));
    assign w_we        = i_cmd.clear_wr || w_out_load;
    assign w_wdata     = i_cmd.clear_wr ? 8'd0 : (i_cmd.copy_wr ? r_rd_data : i_in_byte);
    assign w_raddr     = r_wp - r_dist;

    assign o_stat.wp_last        = (r_wp == '1);
    assign o_stat.in_emits       = w_lit;
    assign o_stat.in_starts_copy = w_body && (r_phase == PH_MATCH2);
    assign o_stat.out_free       = !r_out_valid || i_out_ready;
    assign o_stat.copy_end       = (r_len == LEN_W'(1)) || w_last_byte;

    // header byte merged into the size word
    always_comb begin
        w_hdr_val = r_rem;
        if (r_hdr_idx == '0) begin
            w_hdr_val = {{(SIZE_W-8){1'b0}}, i_in_byte};
        end else begin
            w_hdr_val[{r_hdr_idx[1:0], 3'b000} +: 8] = i_in_byte;
        end
    end

    always_comb begin
        n_wp          = r_wp;
        n_rem         = r_rem;
        n_hdr_idx     = r_hdr_idx;
        n_flag_bits   = r_flag_bits;
        n_flags_left  = r_flags_left;
        n_phase       = r_phase;
        n_pending_low = r_pending_low;
        n_len         = r_len;
        n_dist        = r_dist;

        if (i_cmd.clear_wr) begin
            n_wp = r_wp + 1'b1;
        end

        if (i_cmd.accept) begin
            if (!w_body) begin
                n_rem     = w_hdr_val;
                n_hdr_idx = r_hdr_idx + 1'b1;
                if (r_hdr_idx == HDR_W'(HDR_BYTES - 1)) begin
                    n_phase      = PH_CTRL;
                    n_flags_left = '0;
                    if (w_hdr_val == '0) begin
                        n_hdr_idx   = '0;
                        n_flag_bits = '0;
                    end
                end
            end else begin
                case (r_phase)
                    PH_CTRL: begin
                        n_flag_bits  = i_in_byte;
                        n_flags_left = FLAGS_W'(GROUP_TOKENS);
                        n_phase      = PH_TOKEN;
                    end
                    PH_TOKEN: begin
                        if (r_flag_bits[0]) begin
                            n_pending_low = i_in_byte;
                            n_phase       = PH_MATCH2;
                        end else begin
                            n_flag_bits  = r_flag_bits >> 1;
                            n_flags_left = r_flags_left - 1'b1;
                            n_phase = (r_flags_left == FLAGS_W'(1)) ? PH_CTRL : PH_TOKEN;
                        end
                    end
                    PH_MATCH2: begin
                        n_dist       = {i_in_byte[3:0], r_pending_low};
                        n_len        = {1'b0, i_in_byte[7:4]} + LEN_W'(MIN_MATCH);
                        n_flag_bits  = r_flag_bits >> 1;
                        n_flags_left = r_flags_left - 1'b1;
                        n_phase = (r_flags_left == FLAGS_W'(1)) ? PH_CTRL : PH_TOKEN;
                    end
                    default: begin
                    end
                endcase
            end
        end

        if (i_cmd.copy_wr) begin
            n_len = r_len - 1'b1;
        end

        if (w_out_load) begin
            n_wp  = r_wp + 1'b1;
            n_rem = r_rem - 1'b1;
            // end of stream: drop the rest of the group, expect a header
            if (w_last_byte) begin
                n_hdr_idx    = '0;
                n_phase      = PH_CTRL;
                n_flags_left = '0;
                n_flag_bits  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp          <= '0;
            r_rem         <= '0;
            r_hdr_idx     <= '0;
            r_flag_bits   <= '0;
            r_flags_left  <= '0;
            r_phase       <= PH_CTRL;
            r_pending_low <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_wp          <= n_wp;
            r_rem         <= n_rem;
            r_hdr_idx     <= n_hdr_idx;
            r_flag_bits   <= n_flag_bits;
            r_flags_left  <= n_flags_left;
            r_phase       <= n_phase;
            r_pending_low <= n_pending_low;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_len  <= n_len;
        r_dist <= n_dist;
        if (w_out_load) begin
            r_out_byte    <= w_wdata;
            r_run_last    <= i_cmd.copy_wr ? o_stat.copy_end : 1'b1;
            r_stream_done <= w_last_byte;
        end
    end

    // history window: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_history[r_wp] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.copy_rd) begin
            r_rd_data <= r_history[w_raddr];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_run_last    = r_run_last;
    assign o_stream_done = r_stream_done;

endmodule

`default_nettype wire

>>> hdl/lzsd_ctrl.sv
// ----------------------------------------------------------------------------
// lzsd_ctrl
// Sequencer: window clear after reset, input accept and match copy steps.
// ----------------------------------------------------------------------------
`default_nettype none

module lzsd_ctrl
    import lzsd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd,
    output t_state     o_state
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_stat.wp_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                // hold off only a literal while the output word is still unread
                o_in_ready   = !i_stat.in_emits || i_stat.out_free;
                o_cmd.accept = i_in_valid && o_in_ready;
                if (o_cmd.accept && i_stat.in_starts_copy) begin
                    n_state = S_COPY_RD;
                end
            end
            S_COPY_RD: begin
                o_cmd.copy_rd = 1'b1;
                n_state       = S_COPY_WR;
            end
            S_COPY_WR: begin
                if (i_stat.out_free) begin
                    o_cmd.copy_wr = 1'b1;
                    n_state = i_stat.copy_end ? S_IDLE : S_COPY_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_state = r_state;

endmodule

`default_nettype wire

>>> hdl/lzsd_stream_top.sv
// ----------------------------------------------------------------------------
// lzss_stream_decompressor_core
// Top level: LZSS decompressor with a 4096-byte history window.
// ----------------------------------------------------------------------------
// Usage: feed the compressed stream one byte per input word: a 4-byte
// little-endian decompressed size, then groups of one control byte (bits used
// LSB first) and up to eight tokens. A clear bit is a literal byte; a set bit
// is a two-byte match with a 12-bit backward distance (first byte plus low
// nibble of the second) and a length of 3 to 18 (high nibble plus 3). Each
// output word carries one decompressed byte; run_last flags the last byte
// caused by an input byte and stream_done flags the final byte of the stream,
// after which the next input byte starts a new header. A zero size ends the
// stream with no output.
// Timing: after reset the window is zeroed by a clearing pass over all 4096
// entries, during which no input is taken. Header, control, literal and first
// match bytes are each taken directly in the idle state. A match takes its
// second byte there too, then copies each output byte by a window read and a
// write-back that also loads the output register; the registered window read,
// which must see the byte written just before it when a match overlaps
// itself, sets the copy rate. A literal or a copy write-back waits while the
// output word is still unread. The output register lets header and control
// bytes enter while a produced byte still waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lzss_stream_decompressor_core
    import lzsd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_in_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_run_last,
    output logic            o_stream_done
);

    t_cmd   w_cmd;
    t_stat  w_stat;
    t_state w_state;

    // sequencer: owns the handshake on the input side and steps the copy
    lzsd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_state    (w_state)
    );

    // parser state, window memory and output word
    lzsd_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_in_byte     (i_in_byte),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_out_byte    (o_out_byte),
        .o_run_last    (o_run_last),
        .o_stream_done (o_stream_done)
    );

    // at most one datapath command per cycle
    `ASSERT_ALWAYS(a_cmd_onehot, i_clk, i_rst_n,
        $onehot0({w_cmd.clear_wr, w_cmd.accept, w_cmd.copy_rd, w_cmd.copy_wr}))

    // a copied byte never overwrites an unread output word
    `ASSERT_IMPLIES(a_copy_slot, i_clk, i_rst_n, w_cmd.copy_wr, w_stat.out_free)

    // a literal is taken only when the output word is free
    `ASSERT_IMPLIES(a_lit_slot, i_clk, i_rst_n,
        w_cmd.accept && w_stat.in_emits, w_stat.out_free)

    // a window read is always followed by the write-back step
    `ASSERT_NEXT(a_rd_then_wr, i_clk, i_rst_n, w_cmd.copy_rd, w_state == S_COPY_WR)

endmodule

`default_nettype wire
